/* hw/rtl/lzd_pkg.sv */
// Shared types and constants for the LZ77 type-10 decompressor.
// No dependencies; imported by lzd_hist and lz77_type10_decompressor.
`timescale 1ns / 1ps

package lzd_pkg;

   localparam int unsigned LZD_HISTORY_DEPTH = 4096;
   localparam int unsigned LZD_MAX_DIST      = 4096;
   localparam int unsigned LZD_SIZE_W        = 24;
   localparam int unsigned LZD_DIST_W        = 13;
   localparam int unsigned LZD_LEN_W         = 5;
   localparam logic [4:0]  LZD_LEN_BIAS      = 5'd3;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_EARLY_END = 2'd1;
   localparam logic [1:0] ERR_BAD_REF   = 2'd2;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_FLAG,
      PH_DATA,
      PH_REF2,
      PH_DISCARD
   } phase_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_WRITE
   } seq_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       output_done;
      logic [1:0] error_kind;
   } rsp_type;

endpackage

/* hw/rtl/lzd_hist.sv */
// History ring for the decompressor: one write port, one registered read port.
// Depends on lzd_pkg for the default depth.
`timescale 1ns / 1ps

module lzd_hist import lzd_pkg::*; #(
   parameter int unsigned DEPTH = LZD_HISTORY_DEPTH,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] hist_mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/lz77_type10_decompressor.sv */
// LZ77 type-10 decompressor top level: header/flag parser, copy sequencer, output word.
// Depends on lzd_pkg and lzd_hist.
// A literal or error word appears in the cycle after its input word is taken.
// Header, flag and literal words are handled as they are taken, so a new word may follow
//    at once while the output word is free. A back reference of up to 18 bytes is copied
//    byte by byte (history read, then write and emit), since the registered history read
//    must return before each write. Input is stalled while a copy runs.
// Reset: synchronous, clears parser and sequencer state; the history ring is not cleared.
`timescale 1ns / 1ps

module lz77_type10_decompressor import lzd_pkg::*; #(
   parameter int unsigned HISTORY_DEPTH = LZD_HISTORY_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned AW = $clog2(HISTORY_DEPTH);

   // parser state
   phase_type               phase_ff, phase_in;
   logic [1:0]              hidx_ff, hidx_in;
   logic [LZD_SIZE_W-1:0]   left_ff, left_in;     // bytes still owed to the declared size
   logic [7:0]              flag_ff, flag_in;
   logic [2:0]              fidx_ff, fidx_in;
   logic [7:0]              ref1_ff, ref1_in;
   logic [LZD_DIST_W-1:0]   fill_ff, fill_in;     // bytes produced, saturating at max distance

   // copy sequencer state
   seq_type                 seq_ff, seq_in;
   logic [AW-1:0]           wp_ff, wp_in;
   logic [AW-1:0]           rp_ff, rp_in;
   logic [LZD_LEN_W-1:0]    cnt_ff, cnt_in;
   logic                    last_ff, last_in;

   // output word
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    out_free;
   logic                    accept;
   logic                    emit;
   rsp_type                 emit_data;
   logic                    do_restart;

   logic                    wr_en;
   logic [7:0]              wr_data;
   logic                    rd_en;
   logic [7:0]              hist_rd_data;

   logic [AW-1:0]           wp_next;
   logic [AW-1:0]           rp_next;
   logic [LZD_DIST_W-1:0]   ref_dist;
   logic [LZD_LEN_W-1:0]    ref_len;
   logic                    ref_short;            // reference fits before the declared size
   logic [AW:0]             rp_diff;
   logic [AW:0]             rp_wrap;
   logic [LZD_SIZE_W-1:0]   hdr_size;
   logic [7:0]              in_b;
   logic                    in_last;

   assign in_b    = req_data.in_byte;
   assign in_last = req_data.end_of_input;

   // The output word can take a new value when empty or when it is leaving this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((seq_ff == SEQ_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   // ring pointer arithmetic
   assign wp_next = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
   assign rp_next = (rp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : rp_ff + AW'(1);

   // decode the reference from the held first byte and the incoming second byte
   assign ref_dist  = LZD_DIST_W'({ref1_ff[3:0], in_b}) + LZD_DIST_W'(1);
   assign ref_len   = LZD_LEN_W'(ref1_ff[7:4]) + LZD_LEN_BIAS;
   assign ref_short = LZD_SIZE_W'(ref_len) < left_ff;
   assign rp_diff   = {1'b0, wp_ff} - (AW + 1)'(ref_dist);
   assign rp_wrap   = rp_diff + (AW + 1)'(HISTORY_DEPTH);

   assign hdr_size  = left_ff | {in_b, 16'd0};

   always_comb begin
      phase_in   = phase_ff;
      hidx_in    = hidx_ff;
      left_in    = left_ff;
      flag_in    = flag_ff;
      fidx_in    = fidx_ff;
      ref1_in    = ref1_ff;
      fill_in    = fill_ff;
      seq_in     = seq_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      emit       = 1'b0;
      emit_data  = '0;
      wr_en      = 1'b0;
      wr_data    = in_b;
      rd_en      = 1'b0;
      do_restart = 1'b0;

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               unique case (phase_ff)
                  PH_HEADER: begin
                     if (hidx_ff != 2'd3) begin
                        // type byte ignored; size bytes arrive low first
                        if (hidx_ff == 2'd1) begin
                           left_in = left_ff | {16'd0, in_b};
                        end else if (hidx_ff == 2'd2) begin
                           left_in = left_ff | {8'd0, in_b, 8'd0};
                        end
                        hidx_in = hidx_ff + 2'd1;
                        if (in_last) begin
                           emit                 = 1'b1;
                           emit_data.run_end    = 1'b1;
                           emit_data.error_kind = ERR_EARLY_END;
                           do_restart           = 1'b1;
                        end
                     end else begin
                        left_in = hdr_size;
                        hidx_in = 2'd0;
                        if (hdr_size == '0) begin
                           // empty stream: complete with no result
                           if (in_last) begin
                              do_restart = 1'b1;
                           end else begin
                              phase_in = PH_DISCARD;
                           end
                        end else begin
                           phase_in = PH_FLAG;
                           if (in_last) begin
                              emit                 = 1'b1;
                              emit_data.run_end    = 1'b1;
                              emit_data.error_kind = ERR_EARLY_END;
                              do_restart           = 1'b1;
                           end
                        end
                     end
                  end

                  PH_FLAG: begin
                     flag_in  = in_b;
                     fidx_in  = 3'd0;
                     phase_in = PH_DATA;
                     if (in_last) begin
                        emit                 = 1'b1;
                        emit_data.run_end    = 1'b1;
                        emit_data.error_kind = ERR_EARLY_END;
                        do_restart           = 1'b1;
                     end
                  end

                  PH_DATA: begin
                     if (flag_ff[7]) begin
                        ref1_in  = in_b;
                        phase_in = PH_REF2;
                        if (in_last) begin
                           emit                 = 1'b1;
                           emit_data.run_end    = 1'b1;
                           emit_data.error_kind = ERR_EARLY_END;
                           do_restart           = 1'b1;
                        end
                     end else if (in_last && (left_ff > LZD_SIZE_W'(1))) begin
                        // drop the literal: stream ends short of the declared size
                        emit                 = 1'b1;
                        emit_data.run_end    = 1'b1;
                        emit_data.error_kind = ERR_EARLY_END;
                        do_restart           = 1'b1;
                     end else begin
                        wr_en                 = 1'b1;
                        emit                  = 1'b1;
                        emit_data.out_byte    = in_b;
                        emit_data.run_end     = 1'b1;
                        emit_data.output_done = (left_ff == LZD_SIZE_W'(1));
                        emit_data.error_kind  = ERR_NONE;
                        left_in  = left_ff - LZD_SIZE_W'(1);
                        fill_in  = (fill_ff == LZD_DIST_W'(LZD_MAX_DIST)) ?
                                   fill_ff : fill_ff + LZD_DIST_W'(1);
                        wp_in    = wp_next;
                        flag_in  = {flag_ff[6:0], 1'b0};
                        fidx_in  = fidx_ff + 3'd1;
                        phase_in = (fidx_ff == 3'd7) ? PH_FLAG : PH_DATA;
                        if (left_ff == LZD_SIZE_W'(1)) begin
                           if (in_last) begin
                              do_restart = 1'b1;
                           end else begin
                              phase_in = PH_DISCARD;
                           end
                        end
                     end
                  end

                  PH_REF2: begin
                     if (ref_dist > fill_ff) begin
                        // reference reaches before the output start
                        emit                 = 1'b1;
                        emit_data.run_end    = 1'b1;
                        emit_data.error_kind = ERR_BAD_REF;
                        if (in_last) begin
                           do_restart = 1'b1;
                        end else begin
                           phase_in = PH_DISCARD;
                        end
                     end else if (in_last && ref_short) begin
                        emit                 = 1'b1;
                        emit_data.run_end    = 1'b1;
                        emit_data.error_kind = ERR_EARLY_END;
                        do_restart           = 1'b1;
                     end else begin
                        // start the copy; clip at the declared size
                        cnt_in  = ref_short ? ref_len : left_ff[LZD_LEN_W-1:0];
                        rp_in   = rp_diff[AW] ? rp_wrap[AW-1:0] : rp_diff[AW-1:0];
                        last_in = in_last;
                        seq_in  = SEQ_READ;
                     end
                  end

                  PH_DISCARD: begin
                     if (in_last) begin
                        do_restart = 1'b1;
                     end
                  end

                  default: begin
                     phase_in = PH_DISCARD;
                  end
               endcase
            end
         end

         SEQ_READ: begin
            // fetch one history byte; data is back next cycle
            rd_en  = 1'b1;
            seq_in = SEQ_WRITE;
         end

         SEQ_WRITE: begin
            // hold the fetched byte until the output word frees up
            if (out_free) begin
               wr_en                 = 1'b1;
               wr_data               = hist_rd_data;
               emit                  = 1'b1;
               emit_data.out_byte    = hist_rd_data;
               emit_data.run_end     = (cnt_ff == LZD_LEN_W'(1));
               emit_data.output_done = (left_ff == LZD_SIZE_W'(1));
               emit_data.error_kind  = ERR_NONE;
               left_in = left_ff - LZD_SIZE_W'(1);
               fill_in = (fill_ff == LZD_DIST_W'(LZD_MAX_DIST)) ?
                         fill_ff : fill_ff + LZD_DIST_W'(1);
               wp_in   = wp_next;
               rp_in   = rp_next;
               cnt_in  = cnt_ff - LZD_LEN_W'(1);
               if (cnt_ff == LZD_LEN_W'(1)) begin
                  seq_in   = SEQ_IDLE;
                  flag_in  = {flag_ff[6:0], 1'b0};
                  fidx_in  = fidx_ff + 3'd1;
                  phase_in = (fidx_ff == 3'd7) ? PH_FLAG : PH_DATA;
                  if (left_ff == LZD_SIZE_W'(1)) begin
                     if (last_ff) begin
                        do_restart = 1'b1;
                     end else begin
                        phase_in = PH_DISCARD;
                     end
                  end
               end else begin
                  seq_in = SEQ_READ;
               end
            end
         end

         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase

      // restart: the next word opens a new header
      if (do_restart) begin
         phase_in = PH_HEADER;
         hidx_in  = 2'd0;
         left_in  = '0;
         flag_in  = '0;
         fidx_in  = '0;
         ref1_in  = '0;
         fill_in  = '0;
         wp_in    = '0;
      end

      // output word: load on emit, drop once taken
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hidx_ff      <= 2'd0;
         left_ff      <= '0;
         flag_ff      <= '0;
         fidx_ff      <= '0;
         ref1_ff      <= '0;
         fill_ff      <= '0;
         seq_ff       <= SEQ_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hidx_ff      <= hidx_in;
         left_ff      <= left_in;
         flag_ff      <= flag_in;
         fidx_ff      <= fidx_in;
         ref1_ff      <= ref1_in;
         fill_ff      <= fill_in;
         seq_ff       <= seq_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lzd_hist #(
      .DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rp_ff),
      .rd_data (hist_rd_data)
   );

   // input is held off for the whole copy
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SEQ_IDLE) |-> req_stall)
      else $error("input word taken during a copy");

   // a read is always followed by its write step
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_READ) |=> (seq_ff == SEQ_WRITE))
      else $error("copy read not followed by write");

   // a running copy always has bytes left to move
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SEQ_IDLE) |-> (cnt_ff != '0))
      else $error("copy running with zero count");

   // while items are being decoded, the declared size is not yet reached
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_REF2) |-> (left_ff != '0))
      else $error("item phase with nothing left to produce");

   // an error word ends its run and never completes the output
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.error_kind != ERR_NONE)
         |-> (rsp_data_ff.run_end && !rsp_data_ff.output_done && rsp_data_ff.out_byte == 8'd0))
      else $error("malformed error word");

endmodule
